/* design/tpg_pkg.sv */
package tpg_pkg;

  localparam int COORD_W     = 14;
  localparam int DIM_W       = 15;
  localparam int COLOR_W     = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = DIM_W;

  localparam int MAX_DIM     = 16384;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  // ramp divider: quotient never exceeds one color byte inside the frame
  localparam int DIV_STEPS = COLOR_W;
  localparam int NUM_W     = COORD_W + COLOR_W;

  localparam int BLUE_MUL_X   = 17;
  localparam int BLUE_MUL_Y   = 31;
  localparam int RAMP_MAX     = 255;
  localparam int GRID_MINOR   = 25;
  localparam int GRID_MAJOR   = 100;
  localparam int BORDER_PX    = 3;
  localparam int MARKER_PX    = 30;
  localparam int GREY_LEVEL   = 96;

  // x / 25 as (x * 5243) >> 17, exact for 14-bit x
  localparam int RECIP25       = 5243;
  localparam int RECIP25_SHIFT = 17;
  localparam int QUOT25_W      = 10;
  localparam int MAJOR_LOW_W   = 2;   // 100 = 25 * 4

  localparam int CMP_W = DIM_W + 1;

  typedef enum logic [3:0] {
    OVL_NONE,
    OVL_WHITE,
    OVL_GREY,
    OVL_BLACK,
    OVL_RED,
    OVL_GREEN,
    OVL_BLUE,
    OVL_YELLOW,
    OVL_MAGENTA
  } overlay_t;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [QUOT25_W-1:0] qx;
    logic [QUOT25_W-1:0] qy;
    logic [NUM_W-1:0]    num_r;
    logic [NUM_W-1:0]    num_g;
    logic [COLOR_W-1:0]  blue;
    overlay_t            ovl;
    logic                in_frame;
  } front_t;

  typedef struct packed {
    logic [NUM_W-1:0]   rem_r;
    logic [NUM_W-1:0]   rem_g;
    logic [COLOR_W-1:0] quo_r;
    logic [COLOR_W-1:0] quo_g;
    logic [COLOR_W-1:0] blue;
    overlay_t           ovl;
    logic               in_frame;
  } div_t;

endpackage

/* design/test_pattern_pixel_generator.sv */
// Test pattern pixel generator.
// A request on the pixel channel (pixel_valid, pixel_stall) carries one
// coordinate pixel_x, pixel_y. One result per request comes out on the color
// channel (color_valid, color_stall) as blue, green, red and in_frame, in
// request order. Out-of-frame coordinates, or a frame size of zero or above
// the maximum, give in_frame low and a black pixel.
// The pipeline has one stage of border, marker and center compares, one
// stage of grid compares resolving the overlay, eight stages of a restoring
// divider producing one ramp quotient bit each for red and green, and the
// output register. Throughput is one pixel per cycle unless stalled.
// frame_width and frame_height are written through cfg_write, cfg_index and
// cfg_data, by the user only while no request is in flight (the block does not
// enforce this). Reset sets them to 640 and 480 and empties the pipeline.
// While color_valid is high and color_stall is high the whole pipeline holds
// and pixel_stall is raised; nothing is dropped or repeated.
module test_pattern_pixel_generator
  import tpg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic [COORD_W-1:0]     pixel_x,
  input  logic [COORD_W-1:0]     pixel_y,
  output logic                   color_valid,
  input  logic                   color_stall,
  output logic [COLOR_W-1:0]     blue,
  output logic [COLOR_W-1:0]     green,
  output logic [COLOR_W-1:0]     red,
  output logic                   in_frame,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  logic                 pipe_en;
  logic [COORD_W-1:0]   den_r;
  logic [COORD_W-1:0]   den_g;
  logic                 dims_ok;

  logic                 s1_vld;
  front_t               s1;
  front_t               s1_next;

  logic                 dv_vld [0:DIV_STEPS];
  div_t                 dv [0:DIV_STEPS];
  div_t                 dv_load;
  div_t                 dv_next [1:DIV_STEPS];

  logic [COLOR_W-1:0]   blue_next;
  logic [COLOR_W-1:0]   green_next;
  logic [COLOR_W-1:0]   red_next;

  assign pipe_en     = !(color_valid && color_stall);
  assign pixel_stall = !pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dims_ok = (frame_width != '0) && (frame_height != '0) &&
                   (frame_width <= DIM_W'(MAX_DIM)) && (frame_height <= DIM_W'(MAX_DIM));
  assign den_r   = (frame_width > DIM_W'(1)) ? COORD_W'(frame_width - DIM_W'(1))
                                             : COORD_W'(1);
  assign den_g   = (frame_height > DIM_W'(1)) ? COORD_W'(frame_height - DIM_W'(1))
                                              : COORD_W'(1);

  // stage 1: products, compares against the frame size
  always_comb begin
    logic left, right, top, bottom, border, center;
    left   = CMP_W'(pixel_x) < CMP_W'(MARKER_PX);
    top    = CMP_W'(pixel_y) < CMP_W'(MARKER_PX);
    right  = CMP_W'(pixel_x) + CMP_W'(MARKER_PX) >= CMP_W'(frame_width);
    bottom = CMP_W'(pixel_y) + CMP_W'(MARKER_PX) >= CMP_W'(frame_height);
    border = (CMP_W'(pixel_x) < CMP_W'(BORDER_PX)) ||
             (CMP_W'(pixel_y) < CMP_W'(BORDER_PX)) ||
             (CMP_W'(pixel_x) + CMP_W'(BORDER_PX) >= CMP_W'(frame_width)) ||
             (CMP_W'(pixel_y) + CMP_W'(BORDER_PX) >= CMP_W'(frame_height));
    center = (pixel_x == frame_width[DIM_W-1:1]) || (pixel_y == frame_height[DIM_W-1:1]);

    s1_next.x        = pixel_x;
    s1_next.y        = pixel_y;
    s1_next.qx       = QUOT25_W'((32'(pixel_x) * RECIP25) >> RECIP25_SHIFT);
    s1_next.qy       = QUOT25_W'((32'(pixel_y) * RECIP25) >> RECIP25_SHIFT);
    s1_next.num_r    = NUM_W'(32'(pixel_x) * RAMP_MAX);
    s1_next.num_g    = NUM_W'(32'(pixel_y) * RAMP_MAX);
    s1_next.blue     = COLOR_W'((32'(pixel_x) * BLUE_MUL_X) ^ (32'(pixel_y) * BLUE_MUL_Y));
    s1_next.in_frame = dims_ok && (CMP_W'(pixel_x) < CMP_W'(frame_width)) &&
                       (CMP_W'(pixel_y) < CMP_W'(frame_height));
    if (center) begin
      s1_next.ovl = OVL_MAGENTA;
    end else if (left && top) begin
      s1_next.ovl = OVL_RED;
    end else if (right && top) begin
      s1_next.ovl = OVL_GREEN;
    end else if (left && bottom) begin
      s1_next.ovl = OVL_BLUE;
    end else if (right && bottom) begin
      s1_next.ovl = OVL_YELLOW;
    end else if (border) begin
      s1_next.ovl = OVL_BLACK;
    end else begin
      s1_next.ovl = OVL_NONE;
    end
  end

  // stage 2: grid lines, final overlay, divider load
  always_comb begin
    logic grid_minor, grid_major;
    grid_minor = (s1.x == COORD_W'(32'(s1.qx) * GRID_MINOR)) ||
                 (s1.y == COORD_W'(32'(s1.qy) * GRID_MINOR));
    grid_major = ((s1.x == COORD_W'(32'(s1.qx) * GRID_MINOR)) &&
                  (s1.x[MAJOR_LOW_W-1:0] == '0)) ||
                 ((s1.y == COORD_W'(32'(s1.qy) * GRID_MINOR)) &&
                  (s1.y[MAJOR_LOW_W-1:0] == '0));

    dv_load.rem_r    = s1.num_r;
    dv_load.rem_g    = s1.num_g;
    dv_load.quo_r    = '0;
    dv_load.quo_g    = '0;
    dv_load.blue     = s1.blue;
    dv_load.in_frame = s1.in_frame;
    if (s1.ovl != OVL_NONE) begin
      dv_load.ovl = s1.ovl;
    end else if (grid_major) begin
      dv_load.ovl = OVL_WHITE;
    end else if (grid_minor) begin
      dv_load.ovl = OVL_GREY;
    end else begin
      dv_load.ovl = OVL_NONE;
    end
  end

  // divider stages, one quotient bit each, msb first
  always_comb begin
    logic [NUM_W-1:0] trial_r, trial_g;
    trial_r = '0;
    trial_g = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_next[j+1] = dv[j];
      trial_r = NUM_W'(den_r) << (DIV_STEPS - 1 - j);
      trial_g = NUM_W'(den_g) << (DIV_STEPS - 1 - j);
      if (dv[j].rem_r >= trial_r) begin
        dv_next[j+1].rem_r = dv[j].rem_r - trial_r;
        dv_next[j+1].quo_r[$clog2(DIV_STEPS)'(DIV_STEPS - 1 - j)] = 1'b1;
      end
      if (dv[j].rem_g >= trial_g) begin
        dv_next[j+1].rem_g = dv[j].rem_g - trial_g;
        dv_next[j+1].quo_g[$clog2(DIV_STEPS)'(DIV_STEPS - 1 - j)] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      for (int j = 0; j <= DIV_STEPS; j++) begin
        dv_vld[j] <= 1'b0;
      end
    end else if (pipe_en) begin
      s1_vld    <= pixel_valid;
      dv_vld[0] <= s1_vld;
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_vld[j+1] <= dv_vld[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1    <= s1_next;
      dv[0] <= dv_load;
      for (int j = 1; j <= DIV_STEPS; j++) begin
        dv[j] <= dv_next[j];
      end
    end
  end

  // output color select
  always_comb begin
    blue_next  = dv[DIV_STEPS].blue;
    green_next = dv[DIV_STEPS].quo_g;
    red_next   = dv[DIV_STEPS].quo_r;
    case (dv[DIV_STEPS].ovl)
      OVL_NONE: ;
      OVL_WHITE: begin
        blue_next = '1; green_next = '1; red_next = '1;
      end
      OVL_GREY: begin
        blue_next  = COLOR_W'(GREY_LEVEL);
        green_next = COLOR_W'(GREY_LEVEL);
        red_next   = COLOR_W'(GREY_LEVEL);
      end
      OVL_BLACK: begin
        blue_next = '0; green_next = '0; red_next = '0;
      end
      OVL_RED: begin
        blue_next = '0; green_next = '0; red_next = '1;
      end
      OVL_GREEN: begin
        blue_next = '0; green_next = '1; red_next = '0;
      end
      OVL_BLUE: begin
        blue_next = '1; green_next = '0; red_next = '0;
      end
      OVL_YELLOW: begin
        blue_next = '0; green_next = '1; red_next = '1;
      end
      OVL_MAGENTA: begin
        blue_next = '1; green_next = '0; red_next = '1;
      end
      default: begin
        blue_next = '0; green_next = '0; red_next = '0;
      end
    endcase
    if (!dv[DIV_STEPS].in_frame) begin
      blue_next = '0; green_next = '0; red_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (pipe_en) begin
      color_valid <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      blue     <= blue_next;
      green    <= green_next;
      red      <= red_next;
      in_frame <= dv[DIV_STEPS].in_frame;
    end
  end

endmodule
